FILE: sv/sfts_pkg.sv
// Shared types, constants and the quarter-wave sine table for the stereo frame FIFO.
`default_nettype none

package sfts_pkg;

    // Default ring size in frames; one slot always stays empty.
    localparam int unsigned BUFFER_FRAMES_DEFAULT = 512;

    // Depth of the command queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 2;

    // Tone phase walks 11 steps of 1200 per pull (440 Hz at 48 kHz).
    localparam int unsigned PHASE_W      = 11;
    localparam int unsigned TONE_STEPS   = 1200;
    localparam int unsigned TONE_INC     = 11;
    localparam int unsigned QUARTER_LAST = 300;
    localparam int unsigned HALF_STEPS   = 600;
    localparam int unsigned THREE_QUARTER_STEPS = 900;

    // Quarter table index and magnitude widths (0..300, 0..8192).
    localparam int unsigned QIDX_W = 9;
    localparam int unsigned MAG_W  = 14;

    localparam logic [63:0] PI_Q62      = 64'hC90FDAA22168C234;
    localparam logic [63:0] PI_Q62_STEP = PI_Q62 / 600;

    // Kind of work the back end carries out for one input item.
    typedef enum logic [1:0] {
        OP_WRITE,
        OP_PULL_TONE,
        OP_PULL_BUF
    } op_t;

    // One classified item in the command queue.
    typedef struct packed {
        op_t         op;
        logic [15:0] left_in;
        logic [15:0] right_in;
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic        accepted;
        logic [15:0] left_out;
        logic [15:0] right_out;
        logic        underrun;
    } res_t;

    typedef logic [MAG_W-1:0] quarter_tab_t [0:QUARTER_LAST];

    // Exact floor of (a * b) >> 62, truncated to 64 bits.
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        begin
            prod = {64'd0, a} * {64'd0, b};
            return prod[125:62];
        end
    endfunction

    // trunc(8192 * sin(pi * j / 600)) for the first quadrant, Q62 Taylor series.
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned j);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        begin
            if (j >= QUARTER_LAST)
                return 14'd8192;
            if (j == 100)
                return 14'd4096;
            x    = PI_Q62_STEP * 64'(j);
            x2   = mul_q62(x, x);
            term = x;
            sum  = x;
            term = mul_q62(term, x2) / 64'd6;    sum = sum - term;
            term = mul_q62(term, x2) / 64'd20;   sum = sum + term;
            term = mul_q62(term, x2) / 64'd42;   sum = sum - term;
            term = mul_q62(term, x2) / 64'd72;   sum = sum + term;
            term = mul_q62(term, x2) / 64'd110;  sum = sum - term;
            term = mul_q62(term, x2) / 64'd156;  sum = sum + term;
            term = mul_q62(term, x2) / 64'd210;  sum = sum - term;
            term = mul_q62(term, x2) / 64'd272;  sum = sum + term;
            term = mul_q62(term, x2) / 64'd342;  sum = sum - term;
            term = mul_q62(term, x2) / 64'd420;  sum = sum + term;
            term = mul_q62(term, x2) / 64'd506;  sum = sum - term;
            term = mul_q62(term, x2) / 64'd600;  sum = sum + term;
            term = mul_q62(term, x2) / 64'd702;  sum = sum - term;
            term = mul_q62(term, x2) / 64'd812;  sum = sum + term;
            term = mul_q62(term, x2) / 64'd930;  sum = sum - term;
            term = mul_q62(term, x2) / 64'd1056; sum = sum + term;
            term = mul_q62(term, x2) / 64'd1190; sum = sum - term;
            term = mul_q62(term, x2) / 64'd1332; sum = sum + term;
            term = mul_q62(term, x2) / 64'd1482; sum = sum - term;
            term = mul_q62(term, x2) / 64'd1640; sum = sum + term;
            return MAG_W'(sum >> 49);
        end
    endfunction

    // Builds the constant quarter-wave table at elaboration.
    function automatic quarter_tab_t build_quarter_tab();
        quarter_tab_t tab;
        begin
            for (int unsigned j = 0; j <= QUARTER_LAST; j++)
                tab[j] = quarter_sine(j);
            return tab;
        end
    endfunction

    localparam quarter_tab_t QUARTER_SINE = build_quarter_tab();

endpackage

`default_nettype wire

FILE: sv/stereo_frame_fifo_tone_source.sv
// Top level of the stereo frame ring buffer with sine test-tone source.
//
//  Channel    Direction  Signals                        Contents (low bit up)
//  s_axis     in         tvalid tready tdata tuser      tdata: left_in, right_in; tuser: mode
//  m_axis     out        tvalid tready tdata tuser      tdata: left_out, right_out;
//                                                       tuser: accepted, underrun
//  cfg        in         cfg_we cfg_wdata               tone_enable
//
// An input transfer is registered in a two-entry command queue until the back end takes it.
// Writes and empty-ring pulls then load the result register; buffered and tone pulls first
// pass a wait state, set by the registered frame RAM read port and registered sine table.
// Writes sustain one per cycle while m_axis_tready is high; no item is taken in a wait state.
// Reset clears the pointers, the tone phase and the queue; the frame RAM needs no clearing.
// The queue keeps accepting while a result waits on m_axis; a full queue drops s_axis_tready.
`default_nettype none

module stereo_frame_fifo_tone_source #(
    parameter int unsigned BUFFER_FRAMES = sfts_pkg::BUFFER_FRAMES_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // left_in [15:0], right_in [31:16]
    input  wire logic        s_axis_tuser,   // mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // left_out [15:0], right_out [31:16]
    output logic      [1:0]  m_axis_tuser    // accepted [0], underrun [1]
);

    localparam int unsigned PTR_W = $clog2(BUFFER_FRAMES);

    logic             cmd_valid;
    sfts_pkg::cmd_t   cmd;
    logic             cmd_pop;
    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [31:0]      ram_wdata;
    logic             ram_re;
    logic [PTR_W-1:0] ram_raddr;
    logic [31:0]      ram_rdata;
    sfts_pkg::res_t   res;

    // Input classification and command queue.
    sfts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_mode   (s_axis_tuser),
        .in_left   (s_axis_tdata[15:0]),
        .in_right  (s_axis_tdata[31:16]),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Ring control, tone generation and result register.
    sfts_back #(
        .BUFFER_FRAMES (BUFFER_FRAMES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    // Frame store: right sample in the high half, left in the low half.
    sfts_ram #(
        .WIDTH (32),
        .DEPTH (BUFFER_FRAMES)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Result packing.
    assign m_axis_tdata = {res.right_out, res.left_out};
    assign m_axis_tuser = {res.underrun, res.accepted};

endmodule

`default_nettype wire

FILE: sv/sfts_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module sfts_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/sfts_front.sv
// Front end: takes input transfers, classifies them and queues them for the back end.
`default_nettype none

module sfts_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic          cfg_wdata,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          in_mode,
    input  wire logic [15:0]   in_left,
    input  wire logic [15:0]   in_right,
    output logic               cmd_valid,
    output sfts_pkg::cmd_t     cmd,
    input  wire logic          cmd_pop
);

    localparam int unsigned CNT_W = $clog2(sfts_pkg::QUEUE_DEPTH + 1);
    localparam int unsigned SEL_W = $clog2(sfts_pkg::QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(sfts_pkg::QUEUE_DEPTH);
    localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(sfts_pkg::QUEUE_DEPTH - 1);

    logic           tone_enable_reg;
    sfts_pkg::cmd_t queue_reg [sfts_pkg::QUEUE_DEPTH];
    logic [SEL_W-1:0] wr_sel_reg;
    logic [SEL_W-1:0] rd_sel_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    sfts_pkg::cmd_t   cmd_in;
    logic             push;

    // Mode register for pulls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            tone_enable_reg <= cfg_wdata;
        end
    end

    // Classify the incoming item.
    always_comb
    begin
        cmd_in.left_in  = in_left;
        cmd_in.right_in = in_right;
        if (!in_mode)
            cmd_in.op = sfts_pkg::OP_WRITE;
        else if (tone_enable_reg)
            cmd_in.op = sfts_pkg::OP_PULL_TONE;
        else
            cmd_in.op = sfts_pkg::OP_PULL_BUF;
    end

    assign in_ready  = (count_reg != CNT_FULL);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_sel_reg];

    // Occupancy bookkeeping.
    always_comb
    begin
        case ({push, cmd_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // Queue pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_sel_reg <= '0;
            rd_sel_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_sel_reg <= (wr_sel_reg == SEL_LAST) ? '0 : wr_sel_reg + 1'b1;
            end
            if (cmd_pop)
            begin
                rd_sel_reg <= (rd_sel_reg == SEL_LAST) ? '0 : rd_sel_reg + 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_sel_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

FILE: sv/sfts_back.sv
// Back end: ring pointers, tone generator and the result register.
`default_nettype none

module sfts_back #(
    parameter int unsigned BUFFER_FRAMES = sfts_pkg::BUFFER_FRAMES_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cmd_valid,
    input  wire sfts_pkg::cmd_t                   cmd,
    output logic                                  cmd_pop,
    output logic                                  ram_we,
    output logic [$clog2(BUFFER_FRAMES)-1:0]      ram_waddr,
    output logic [31:0]                           ram_wdata,
    output logic                                  ram_re,
    output logic [$clog2(BUFFER_FRAMES)-1:0]      ram_raddr,
    input  wire logic [31:0]                      ram_rdata,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output sfts_pkg::res_t                        out_res
);

    localparam int unsigned PTR_W = $clog2(BUFFER_FRAMES);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_FRAMES - 1);
    localparam int unsigned PW = sfts_pkg::PHASE_W;
    localparam int unsigned QW = sfts_pkg::QIDX_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_TONE
    } state_t;

    state_t                        state_reg;
    logic                          out_valid_reg;
    sfts_pkg::res_t                out_res_reg;
    logic [PTR_W-1:0]              wr_ptr_reg;
    logic [PTR_W-1:0]              rd_ptr_reg;
    logic [PTR_W-1:0]              wr_ptr_next;
    logic [PTR_W-1:0]              rd_ptr_next;
    logic [PW-1:0]                 phase_reg;
    logic [PW-1:0]                 phase_next;
    logic [PW-1:0]                 phase_sum;
    logic [sfts_pkg::MAG_W-1:0]    tone_mag_reg;
    logic                          tone_neg_reg;
    logic [QW-1:0]                 quarter_idx;
    logic                          quarter_neg;
    logic [15:0]                   tone_abs;
    logic [15:0]                   tone_sample;
    logic                          out_free;
    logic                          full;
    logic                          empty;
    logic                          take;
    logic                          out_load;

    // Ring status and next pointers.
    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        full        = (wr_ptr_next == rd_ptr_reg);
        empty       = (wr_ptr_reg == rd_ptr_reg);
    end

    // A command is taken only when the result register is free or draining.
    assign out_free = !out_valid_reg || out_ready;
    assign take     = (state_reg == ST_IDLE) && cmd_valid && out_free;
    assign cmd_pop  = take;

    // The result register is loaded by writes, empty-ring pulls and the wait state of a pull.
    assign out_load = (take && (cmd.op != sfts_pkg::OP_PULL_TONE) &&
                       !((cmd.op == sfts_pkg::OP_PULL_BUF) && !empty)) ||
                      (state_reg == ST_READ) || (state_reg == ST_TONE);

    // Frame store access.
    assign ram_we    = take && (cmd.op == sfts_pkg::OP_WRITE) && !full;
    assign ram_waddr = wr_ptr_reg;
    assign ram_wdata = {cmd.right_in, cmd.left_in};
    assign ram_re    = take && (cmd.op == sfts_pkg::OP_PULL_BUF) && !empty;
    assign ram_raddr = rd_ptr_reg;

    // Fold the phase into a first-quadrant index and a sign.
    always_comb
    begin
        if (phase_reg < PW'(sfts_pkg::QUARTER_LAST))
        begin
            quarter_idx = QW'(phase_reg);
            quarter_neg = 1'b0;
        end
        else if (phase_reg <= PW'(sfts_pkg::HALF_STEPS))
        begin
            quarter_idx = QW'(PW'(sfts_pkg::HALF_STEPS) - phase_reg);
            quarter_neg = 1'b0;
        end
        else if (phase_reg < PW'(sfts_pkg::THREE_QUARTER_STEPS))
        begin
            quarter_idx = QW'(phase_reg - PW'(sfts_pkg::HALF_STEPS));
            quarter_neg = 1'b1;
        end
        else
        begin
            quarter_idx = QW'(PW'(sfts_pkg::TONE_STEPS) - phase_reg);
            quarter_neg = 1'b1;
        end
    end

    // Phase advance modulo the table period.
    always_comb
    begin
        phase_sum = phase_reg + PW'(sfts_pkg::TONE_INC);
        if (phase_sum >= PW'(sfts_pkg::TONE_STEPS))
            phase_next = phase_sum - PW'(sfts_pkg::TONE_STEPS);
        else
            phase_next = phase_sum;
    end

    // Signed tone sample from the registered magnitude.
    assign tone_abs    = 16'(tone_mag_reg);
    assign tone_sample = tone_neg_reg ? (16'd0 - tone_abs) : tone_abs;

    // Sequencer, pointers and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            phase_reg     <= '0;
            tone_mag_reg  <= '0;
            tone_neg_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        case (cmd.op)
                            sfts_pkg::OP_WRITE:
                            begin
                                out_res_reg   <= '{accepted: !full, left_out: 16'd0,
                                                   right_out: 16'd0, underrun: 1'b0};
                                if (!full)
                                begin
                                    wr_ptr_reg <= wr_ptr_next;
                                end
                            end
                            sfts_pkg::OP_PULL_TONE:
                            begin
                                tone_mag_reg <= sfts_pkg::QUARTER_SINE[quarter_idx];
                                tone_neg_reg <= quarter_neg;
                                phase_reg    <= phase_next;
                                state_reg    <= ST_TONE;
                            end
                            sfts_pkg::OP_PULL_BUF:
                            begin
                                if (empty)
                                begin
                                    out_res_reg   <= '{accepted: 1'b0, left_out: 16'd0,
                                                       right_out: 16'd0, underrun: 1'b1};
                                end
                                else
                                begin
                                    rd_ptr_reg <= rd_ptr_next;
                                    state_reg  <= ST_READ;
                                end
                            end
                            default:
                            begin
                                out_res_reg   <= '0;
                            end
                        endcase
                    end
                end
                ST_READ:
                begin
                    out_res_reg   <= '{accepted: 1'b0, left_out: ram_rdata[15:0],
                                       right_out: ram_rdata[31:16], underrun: 1'b0};
                    state_reg     <= ST_IDLE;
                end
                ST_TONE:
                begin
                    out_res_reg   <= '{accepted: 1'b0, left_out: tone_sample,
                                       right_out: tone_sample, underrun: 1'b0};
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // A buffered or tone pull always has its result valid once its wait state is over.
    a_wait_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_TONE) |=> out_valid_reg)
        else $error("pull result not delivered after wait state");

    // Pointers stay inside the ring.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg <= PTR_LAST) && (rd_ptr_reg <= PTR_LAST))
        else $error("ring pointer out of range");

    // Tone phase stays inside one period.
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg < PW'(sfts_pkg::TONE_STEPS))
        else $error("tone phase out of range");

    // A stored write advances the write pointer.
    a_write_advances: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (wr_ptr_reg != $past(wr_ptr_reg)))
        else $error("stored write did not advance the write pointer");

    // A result never claims both a stored write and an underrun.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_res_reg.accepted && out_res_reg.underrun))
        else $error("accepted and underrun both set");

endmodule

`default_nettype wire
